/* rtl/eabc_pkg.sv */
// eabc_pkg: shared types and constants of the 8-bit accumulator cpu core
// holds item and result word structs, sequencer states, decode struct and flag masks
// no dependencies
package eabc_pkg;

    localparam int MEM_DEPTH_DEF  = 65536;
    localparam int PORT_COUNT_DEF = 256;

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_EXEC = 2'd1,
        KIND_PORT = 2'd2,
        KIND_INT  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] address;
        logic [7:0]  data;
        logic [7:0]  port;
        logic [2:0]  vector;
    } item_t;

    typedef struct packed {
        logic [15:0] prog_counter;
        logic [15:0] stack_ptr;
        logic [7:0]  accum;
        logic [7:0]  flag_byte;
        logic        out_valid;
        logic [7:0]  out_port;
        logic [7:0]  out_data;
        logic [4:0]  states_taken;
        logic        halted;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DEC,
        ST_IMM_LO,
        ST_IMM_HI,
        ST_MRD_LO,
        ST_MRD_HI,
        ST_EXEC,
        ST_WR2,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        BASE_HL,
        BASE_BC,
        BASE_DE,
        BASE_SP,
        BASE_IMM
    } base_t;

    typedef struct packed {
        logic [1:0] imm_cnt;
        logic [1:0] mrd_cnt;
        base_t      base;
    } dec_t;

    localparam logic [7:0] F_CY     = 8'h01;
    localparam logic [7:0] F_P      = 8'h04;
    localparam logic [7:0] F_AC     = 8'h10;
    localparam logic [7:0] F_Z      = 8'h40;
    localparam logic [7:0] F_S      = 8'h80;
    localparam logic [7:0] F_ALL    = 8'hD5;
    localparam logic [7:0] F_PSW_ONE = 8'h02;
    localparam logic [7:0] OP_HLT   = 8'h76;

endpackage

/* rtl/eight_bit_accumulator_cpu_core.sv */
// eight_bit_accumulator_cpu_core: 8080-compatible core with its own byte memory
// depends on eabc_pkg
//
// usage: an item word is taken on item when start is high and busy is low. kind selects
// a memory byte load, an input port write, an interrupt (rst to vector*8 when enabled)
// or the execution of one instruction at pc. busy stays high until the result word has
// been shown; done is high for exactly one cycle with the result word on result, which
// reports pc, sp, a, flags, any out port write, the instruction's state count and halt.
// load, port and disabled interrupt items and an execute item while halted go straight to
// done; a taken interrupt passes through a second write state; an instruction passes
// through decode, its immediate and operand reads, execute and, if needed, a second write.
// the next item can be taken in the cycle after done. the sequence is set by the single
// memory port: one state per byte fetched or read (opcode, immediates, operands), one
// state for execute and one more for a second byte written.
// memory has a registered synchronous read; its contents are undefined after reset.
// reset clears pc, sp, registers, flags, interrupt enable, halt and the port table
// (through per-entry valid bits). the receiver cannot hold results off.
// MEM_DEPTH and PORT_COUNT are taken as powers of two; addresses and ports wrap.
module eight_bit_accumulator_cpu_core
    import eabc_pkg::*;
#(
    parameter int MEM_DEPTH  = MEM_DEPTH_DEF,
    parameter int PORT_COUNT = PORT_COUNT_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  item_t   item,
    output logic    busy,
    output logic    done,
    output result_t result
);

    localparam int AW = $clog2(MEM_DEPTH);
    localparam int PW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

    // ---------------- helpers
    function automatic logic [7:0] szp_f(input logic [7:0] v);
        return {v[7], (v == 8'h00), 3'b000, ~^v, 2'b00};
    endfunction

    function automatic logic [7:0] mkf_f(input logic [7:0] r, input logic ac, input logic cy);
        return szp_f(r) | {3'b000, ac, 3'b000, cy};
    endfunction

    // {ac, cy, sum}
    function automatic logic [9:0] add8_f(input logic [7:0] a, input logic [7:0] b,
                                          input logic cin);
        logic [8:0] s;
        logic [4:0] h;
        s = {1'b0, a} + {1'b0, b} + {8'h00, cin};
        h = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cin};
        return {h[4], s[8], s[7:0]};
    endfunction

    // {flags, result}
    function automatic logic [15:0] alu_f(input logic [2:0] op, input logic [7:0] a,
                                          input logic [7:0] v, input logic [7:0] f);
        logic [9:0] t;
        logic [7:0] r;
        logic [7:0] nf;
        t  = 10'h000;
        r  = 8'h00;
        nf = 8'h00;
        case (op)
            3'd0:
            begin
                t  = add8_f(a, v, 1'b0);
                r  = t[7:0];
                nf = mkf_f(r, t[9], t[8]);
            end
            3'd1:
            begin
                t  = add8_f(a, v, f[0]);
                r  = t[7:0];
                nf = mkf_f(r, t[9], t[8]);
            end
            3'd2, 3'd7:
            begin
                t  = add8_f(a, ~v, 1'b1);
                r  = t[7:0];
                nf = mkf_f(r, t[9], ~t[8]);
            end
            3'd3:
            begin
                t  = add8_f(a, ~v, ~f[0]);
                r  = t[7:0];
                nf = mkf_f(r, t[9], ~t[8]);
            end
            3'd4:
            begin
                r  = a & v;
                nf = mkf_f(r, a[3] | v[3], 1'b0);
            end
            3'd5:
            begin
                r  = a ^ v;
                nf = mkf_f(r, 1'b0, 1'b0);
            end
            default:
            begin
                r  = a | v;
                nf = mkf_f(r, 1'b0, 1'b0);
            end
        endcase
        return {nf, r};
    endfunction

    function automatic logic cond_f(input logic [2:0] c, input logic [7:0] f);
        logic t;
        case (c[2:1])
            2'd0:    t = f[6];
            2'd1:    t = f[0];
            2'd2:    t = f[2];
            default: t = f[7];
        endcase
        return c[0] ? t : ~t;
    endfunction

    // which immediates and memory operands an opcode needs
    function automatic dec_t dec_f(input logic [7:0] op);
        dec_t d;
        d.imm_cnt = 2'd0;
        d.mrd_cnt = 2'd0;
        d.base    = BASE_HL;
        case (op[7:6])
            2'd0:
            begin
                case (op[2:0])
                    3'd1:
                        if (!op[3]) d.imm_cnt = 2'd2;
                    3'd2:
                    begin
                        case (op[5:3])
                            3'd1:
                            begin
                                d.mrd_cnt = 2'd1;
                                d.base    = BASE_BC;
                            end
                            3'd3:
                            begin
                                d.mrd_cnt = 2'd1;
                                d.base    = BASE_DE;
                            end
                            3'd4, 3'd6:
                                d.imm_cnt = 2'd2;
                            3'd5:
                            begin
                                d.imm_cnt = 2'd2;
                                d.mrd_cnt = 2'd2;
                                d.base    = BASE_IMM;
                            end
                            3'd7:
                            begin
                                d.imm_cnt = 2'd2;
                                d.mrd_cnt = 2'd1;
                                d.base    = BASE_IMM;
                            end
                            default: ;
                        endcase
                    end
                    3'd4, 3'd5:
                        if (op[5:3] == 3'd6) d.mrd_cnt = 2'd1;
                    3'd6:
                        d.imm_cnt = 2'd1;
                    default: ;
                endcase
            end
            2'd1, 2'd2:
                if (op[2:0] == 3'd6) d.mrd_cnt = 2'd1;
            default:
            begin
                case (op[2:0])
                    3'd0:
                    begin
                        d.mrd_cnt = 2'd2;
                        d.base    = BASE_SP;
                    end
                    3'd1:
                        if (!op[3] || !op[5])
                        begin
                            d.mrd_cnt = 2'd2;
                            d.base    = BASE_SP;
                        end
                    3'd2, 3'd4:
                        d.imm_cnt = 2'd2;
                    3'd3:
                    begin
                        if (op[5:3] inside {3'd0, 3'd1}) d.imm_cnt = 2'd2;
                        else if (op[5:3] inside {3'd2, 3'd3}) d.imm_cnt = 2'd1;
                        else if (op[5:3] == 3'd4)
                        begin
                            d.mrd_cnt = 2'd2;
                            d.base    = BASE_SP;
                        end
                    end
                    3'd5:
                        if (op[3]) d.imm_cnt = 2'd2;
                    3'd6:
                        d.imm_cnt = 2'd1;
                    default: ;
                endcase
            end
        endcase
        return d;
    endfunction

    function automatic logic [PW-1:0] pidx_f(input logic [7:0] n);
        logic [PW-1:0] i;
        i = n[PW-1:0];
        if (PORT_COUNT == 1) i = '0;
        return i;
    endfunction

    // ---------------- registers
    state_t      state_reg, state_next;
    logic [15:0] pc_reg, pc_next, sp_reg, sp_next;
    logic [7:0]  b_reg, b_next, c_reg, c_next, d_reg, d_next, e_reg, e_next;
    logic [7:0]  h_reg, h_next, l_reg, l_next, a_reg, a_next, f_reg, f_next;
    logic        ie_reg, ie_next, halt_reg, halt_next;
    logic [7:0]  op_reg, op_next;
    logic [7:0]  imm_lo_reg, imm_lo_next, imm_hi_reg, imm_hi_next;
    logic [7:0]  md_lo_reg, md_lo_next;
    logic [15:0] maddr_reg, maddr_next;
    logic [1:0]  imm_cnt_reg, imm_cnt_next, mrd_cnt_reg, mrd_cnt_next;
    logic [15:0] wa2_reg, wa2_next;
    logic [7:0]  wd2_reg, wd2_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_port_reg, out_port_next, out_data_reg, out_data_next;
    logic [4:0]  states_reg, states_next;
    logic [1:0]  kind_reg, kind_next;
    logic [PORT_COUNT-1:0] port_vld_reg;

    // ---------------- memories
    logic [7:0]  main_mem [MEM_DEPTH];
    logic [7:0]  port_mem [PORT_COUNT];
    logic [7:0]  mem_rdata_reg;
    logic [7:0]  port_rdata_reg;
    logic        port_rvld_reg;

    logic [15:0] mem_raddr, mem_waddr;
    logic        mem_we;
    logic [7:0]  mem_wdata;
    logic        port_we;
    logic [PW-1:0] port_widx, port_ridx;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            main_mem[mem_waddr[AW-1:0]] <= mem_wdata;
        end
        mem_rdata_reg <= main_mem[mem_raddr[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (port_we)
        begin
            port_mem[port_widx] <= item.data;
        end
        port_rdata_reg <= port_mem[port_ridx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_vld_reg  <= '0;
            port_rvld_reg <= 1'b0;
        end
        else
        begin
            if (port_we)
            begin
                port_vld_reg[port_widx] <= 1'b1;
            end
            port_rvld_reg <= port_vld_reg[port_ridx];
        end
    end

    // ---------------- operand views
    logic [15:0] bc, de, hlw, imm16, md16;
    logic [7:0]  src_val, dst_val, port_val;
    logic [2:0]  op_x_y, op_z;
    logic [1:0]  op_x, op_p;
    logic        op_q;
    dec_t        dec;

    assign bc       = {b_reg, c_reg};
    assign de       = {d_reg, e_reg};
    assign hlw      = {h_reg, l_reg};
    assign imm16    = {imm_hi_reg, imm_lo_reg};
    assign md16     = {mem_rdata_reg, md_lo_reg};
    assign port_val = port_rvld_reg ? port_rdata_reg : 8'h00;
    assign op_x     = op_reg[7:6];
    assign op_x_y   = op_reg[5:3];
    assign op_z     = op_reg[2:0];
    assign op_p     = op_reg[5:4];
    assign op_q     = op_reg[3];
    assign dec      = dec_f(mem_rdata_reg);
    assign port_ridx = pidx_f(mem_rdata_reg);

    always_comb
    begin
        case (op_z)
            3'd0:    src_val = b_reg;
            3'd1:    src_val = c_reg;
            3'd2:    src_val = d_reg;
            3'd3:    src_val = e_reg;
            3'd4:    src_val = h_reg;
            3'd5:    src_val = l_reg;
            3'd6:    src_val = md_lo_reg;
            default: src_val = a_reg;
        endcase
        case (op_x_y)
            3'd0:    dst_val = b_reg;
            3'd1:    dst_val = c_reg;
            3'd2:    dst_val = d_reg;
            3'd3:    dst_val = e_reg;
            3'd4:    dst_val = h_reg;
            3'd5:    dst_val = l_reg;
            3'd6:    dst_val = md_lo_reg;
            default: dst_val = a_reg;
        endcase
    end

    // ---------------- sequencer
    always_comb
    begin
        logic        r_we;
        logic [7:0]  r_val;
        logic        rp_we;
        logic [15:0] rp_val, rp_cur, w;
        logic        w1_en, w2_en, push_en;
        logic [15:0] w1_addr, push_val;
        logic [7:0]  w1_data, v;
        logic [16:0] s17;
        logic [15:0] t16;
        logic [3:0]  lsb, msb;
        logic [7:0]  corr;
        logic        ncy;
        logic [9:0]  t10;

        state_next     = state_reg;
        pc_next        = pc_reg;
        sp_next        = sp_reg;
        b_next = b_reg; c_next = c_reg; d_next = d_reg; e_next = e_reg;
        h_next = h_reg; l_next = l_reg; a_next = a_reg; f_next = f_reg;
        ie_next        = ie_reg;
        halt_next      = halt_reg;
        op_next        = op_reg;
        imm_lo_next    = imm_lo_reg;
        imm_hi_next    = imm_hi_reg;
        md_lo_next     = md_lo_reg;
        maddr_next     = maddr_reg;
        imm_cnt_next   = imm_cnt_reg;
        mrd_cnt_next   = mrd_cnt_reg;
        wa2_next       = wa2_reg;
        wd2_next       = wd2_reg;
        out_valid_next = out_valid_reg;
        out_port_next  = out_port_reg;
        out_data_next  = out_data_reg;
        states_next    = states_reg;
        kind_next      = kind_reg;

        mem_raddr = pc_reg;
        mem_we    = 1'b0;
        mem_waddr = wa2_reg;
        mem_wdata = wd2_reg;
        port_we   = 1'b0;
        port_widx = pidx_f(item.port);

        r_we = 1'b0; r_val = 8'h00;
        rp_we = 1'b0; rp_val = 16'h0000; rp_cur = sp_reg; w = 16'h0000;
        w1_en = 1'b0; w1_addr = 16'h0000; w1_data = 8'h00;
        w2_en = 1'b0; push_en = 1'b0; push_val = 16'h0000;
        v = 8'h00; s17 = 17'h00000; t16 = 16'h0000;
        lsb = 4'h0; msb = 4'h0; corr = 8'h00; ncy = 1'b0; t10 = 10'h000;

        case (op_p)
            2'd0:    rp_cur = bc;
            2'd1:    rp_cur = de;
            2'd2:    rp_cur = hlw;
            default: rp_cur = sp_reg;
        endcase

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    kind_next      = item.kind;
                    out_valid_next = 1'b0;
                    out_port_next  = 8'h00;
                    out_data_next  = 8'h00;
                    states_next    = 5'd0;
                    state_next     = ST_DONE;
                    case (item.kind)
                        KIND_LOAD:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = item.address;
                            mem_wdata = item.data;
                        end
                        KIND_PORT:
                            port_we = 1'b1;
                        KIND_INT:
                        begin
                            if (ie_reg)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = sp_reg - 16'd1;
                                mem_wdata  = pc_reg[15:8];
                                wa2_next   = sp_reg - 16'd2;
                                wd2_next   = pc_reg[7:0];
                                sp_next    = sp_reg - 16'd2;
                                pc_next    = {10'd0, item.vector, 3'd0};
                                ie_next    = 1'b0;
                                halt_next  = 1'b0;
                                state_next = ST_WR2;
                            end
                        end
                        default:
                            // opcode read at pc is already under way
                            if (!halt_reg) state_next = ST_DEC;
                    endcase
                end
            end

            ST_DEC:
            begin
                op_next      = mem_rdata_reg;
                pc_next      = pc_reg + 16'd1;
                imm_cnt_next = dec.imm_cnt;
                mrd_cnt_next = dec.mrd_cnt;
                case (dec.base)
                    BASE_BC: maddr_next = bc;
                    BASE_DE: maddr_next = de;
                    BASE_SP: maddr_next = sp_reg;
                    default: maddr_next = hlw;
                endcase
                if (dec.imm_cnt != 2'd0)
                begin
                    mem_raddr  = pc_reg + 16'd1;
                    state_next = ST_IMM_LO;
                end
                else if (dec.mrd_cnt != 2'd0)
                begin
                    mem_raddr  = maddr_next;
                    state_next = ST_MRD_LO;
                end
                else
                begin
                    state_next = ST_EXEC;
                end
            end

            ST_IMM_LO:
            begin
                // the port table is read here too, for an IN
                imm_lo_next = mem_rdata_reg;
                pc_next     = pc_reg + 16'd1;
                if (imm_cnt_reg == 2'd2)
                begin
                    mem_raddr  = pc_reg + 16'd1;
                    state_next = ST_IMM_HI;
                end
                else
                begin
                    state_next = ST_EXEC;
                end
            end

            ST_IMM_HI:
            begin
                imm_hi_next = mem_rdata_reg;
                pc_next     = pc_reg + 16'd1;
                if (mrd_cnt_reg != 2'd0)
                begin
                    maddr_next = {mem_rdata_reg, imm_lo_reg};
                    mem_raddr  = maddr_next;
                    state_next = ST_MRD_LO;
                end
                else
                begin
                    state_next = ST_EXEC;
                end
            end

            ST_MRD_LO:
            begin
                md_lo_next = mem_rdata_reg;
                if (mrd_cnt_reg == 2'd2)
                begin
                    mem_raddr  = maddr_reg + 16'd1;
                    state_next = ST_MRD_HI;
                end
                else
                begin
                    state_next = ST_EXEC;
                end
            end

            ST_MRD_HI:
            begin
                // high byte stays in the read register for execute
                mem_raddr  = maddr_reg + 16'd1;
                state_next = ST_EXEC;
            end

            ST_EXEC:
            begin
                // memory read data still holds the high operand byte
                mem_raddr = maddr_reg + 16'd1;
                if (op_reg == OP_HLT)
                begin
                    halt_next   = 1'b1;
                    states_next = 5'd7;
                end
                else
                begin
                    case (op_x)
                        2'd1:
                        begin
                            r_we  = 1'b1;
                            r_val = src_val;
                            states_next = (op_x_y == 3'd6 || op_z == 3'd6) ? 5'd7 : 5'd5;
                        end
                        2'd2:
                        begin
                            t16    = alu_f(op_x_y, a_reg, src_val, f_reg);
                            f_next = t16[15:8];
                            if (op_x_y != 3'd7) a_next = t16[7:0];
                            states_next = (op_z == 3'd6) ? 5'd7 : 5'd4;
                        end
                        2'd0:
                        begin
                            case (op_z)
                                3'd0:
                                    states_next = 5'd4;
                                3'd1:
                                begin
                                    rp_we = 1'b1;
                                    if (!op_q)
                                    begin
                                        rp_val = imm16;
                                    end
                                    else
                                    begin
                                        // dad always lands in hl
                                        s17    = {1'b0, hlw} + {1'b0, rp_cur};
                                        f_next = (f_reg & ~F_CY) | {7'd0, s17[16]};
                                        h_next = s17[15:8];
                                        l_next = s17[7:0];
                                        rp_we  = 1'b0;
                                    end
                                    states_next = 5'd10;
                                end
                                3'd2:
                                begin
                                    case (op_x_y)
                                        3'd0:
                                        begin
                                            w1_en = 1'b1; w1_addr = bc; w1_data = a_reg;
                                            states_next = 5'd7;
                                        end
                                        3'd2:
                                        begin
                                            w1_en = 1'b1; w1_addr = de; w1_data = a_reg;
                                            states_next = 5'd7;
                                        end
                                        3'd1, 3'd3:
                                        begin
                                            a_next      = md_lo_reg;
                                            states_next = 5'd7;
                                        end
                                        3'd4:
                                        begin
                                            w1_en = 1'b1; w1_addr = imm16; w1_data = l_reg;
                                            w2_en = 1'b1;
                                            wa2_next = imm16 + 16'd1;
                                            wd2_next = h_reg;
                                            states_next = 5'd16;
                                        end
                                        3'd5:
                                        begin
                                            l_next = md_lo_reg;
                                            h_next = mem_rdata_reg;
                                            states_next = 5'd16;
                                        end
                                        3'd6:
                                        begin
                                            w1_en = 1'b1; w1_addr = imm16; w1_data = a_reg;
                                            states_next = 5'd13;
                                        end
                                        default:
                                        begin
                                            a_next      = md_lo_reg;
                                            states_next = 5'd13;
                                        end
                                    endcase
                                end
                                3'd3:
                                begin
                                    rp_we  = 1'b1;
                                    rp_val = op_q ? (rp_cur - 16'd1) : (rp_cur + 16'd1);
                                    states_next = 5'd5;
                                end
                                3'd4:
                                begin
                                    v      = dst_val + 8'd1;
                                    r_we   = 1'b1;
                                    r_val  = v;
                                    f_next = mkf_f(v, v[3:0] == 4'h0, f_reg[0]);
                                    states_next = (op_x_y == 3'd6) ? 5'd10 : 5'd5;
                                end
                                3'd5:
                                begin
                                    v      = dst_val - 8'd1;
                                    r_we   = 1'b1;
                                    r_val  = v;
                                    f_next = mkf_f(v, v[3:0] != 4'hF, f_reg[0]);
                                    states_next = (op_x_y == 3'd6) ? 5'd10 : 5'd5;
                                end
                                3'd6:
                                begin
                                    r_we  = 1'b1;
                                    r_val = imm_lo_reg;
                                    states_next = (op_x_y == 3'd6) ? 5'd10 : 5'd7;
                                end
                                default:
                                begin
                                    states_next = 5'd4;
                                    case (op_x_y)
                                        3'd0:
                                        begin
                                            f_next = (f_reg & ~F_CY) | {7'd0, a_reg[7]};
                                            a_next = {a_reg[6:0], a_reg[7]};
                                        end
                                        3'd1:
                                        begin
                                            f_next = (f_reg & ~F_CY) | {7'd0, a_reg[0]};
                                            a_next = {a_reg[0], a_reg[7:1]};
                                        end
                                        3'd2:
                                        begin
                                            f_next = (f_reg & ~F_CY) | {7'd0, a_reg[7]};
                                            a_next = {a_reg[6:0], f_reg[0]};
                                        end
                                        3'd3:
                                        begin
                                            f_next = (f_reg & ~F_CY) | {7'd0, a_reg[0]};
                                            a_next = {f_reg[0], a_reg[7:1]};
                                        end
                                        3'd4:
                                        begin
                                            // daa
                                            lsb  = a_reg[3:0];
                                            msb  = a_reg[7:4];
                                            corr = 8'h00;
                                            ncy  = f_reg[0];
                                            if (lsb > 4'd9 || f_reg[4]) corr = corr | 8'h06;
                                            if (msb > 4'd9 || f_reg[0] ||
                                                (msb >= 4'd9 && lsb > 4'd9))
                                            begin
                                                corr = corr | 8'h60;
                                                ncy  = 1'b1;
                                            end
                                            t10    = add8_f(a_reg, corr, 1'b0);
                                            a_next = t10[7:0];
                                            f_next = mkf_f(t10[7:0], t10[9], ncy);
                                        end
                                        3'd5:
                                            a_next = ~a_reg;
                                        3'd6:
                                            f_next = f_reg | F_CY;
                                        default:
                                            f_next = f_reg ^ F_CY;
                                    endcase
                                end
                            endcase
                        end
                        default:
                        begin
                            case (op_z)
                                3'd0:
                                begin
                                    if (cond_f(op_x_y, f_reg))
                                    begin
                                        pc_next = md16;
                                        sp_next = sp_reg + 16'd2;
                                        states_next = 5'd11;
                                    end
                                    else
                                    begin
                                        states_next = 5'd5;
                                    end
                                end
                                3'd1:
                                begin
                                    states_next = 5'd10;
                                    if (!op_q)
                                    begin
                                        sp_next = sp_reg + 16'd2;
                                        if (op_p == 2'd3)
                                        begin
                                            f_next = md_lo_reg & F_ALL;
                                            a_next = mem_rdata_reg;
                                        end
                                        else
                                        begin
                                            rp_we  = 1'b1;
                                            rp_val = md16;
                                        end
                                    end
                                    else if (!op_p[1])
                                    begin
                                        pc_next = md16;
                                        sp_next = sp_reg + 16'd2;
                                    end
                                    else if (op_p == 2'd2)
                                    begin
                                        pc_next     = hlw;
                                        states_next = 5'd5;
                                    end
                                    else
                                    begin
                                        sp_next     = hlw;
                                        states_next = 5'd5;
                                    end
                                end
                                3'd2:
                                begin
                                    if (cond_f(op_x_y, f_reg)) pc_next = imm16;
                                    states_next = 5'd10;
                                end
                                3'd3:
                                begin
                                    states_next = 5'd4;
                                    case (op_x_y)
                                        3'd0, 3'd1:
                                        begin
                                            pc_next     = imm16;
                                            states_next = 5'd10;
                                        end
                                        3'd2:
                                        begin
                                            out_valid_next = 1'b1;
                                            out_port_next  = imm_lo_reg;
                                            out_data_next  = a_reg;
                                            states_next    = 5'd10;
                                        end
                                        3'd3:
                                        begin
                                            a_next      = port_val;
                                            states_next = 5'd10;
                                        end
                                        3'd4:
                                        begin
                                            w1_en = 1'b1; w1_addr = sp_reg; w1_data = l_reg;
                                            w2_en = 1'b1;
                                            wa2_next = sp_reg + 16'd1;
                                            wd2_next = h_reg;
                                            l_next = md_lo_reg;
                                            h_next = mem_rdata_reg;
                                            states_next = 5'd18;
                                        end
                                        3'd5:
                                        begin
                                            d_next = h_reg; h_next = d_reg;
                                            e_next = l_reg; l_next = e_reg;
                                        end
                                        3'd6:
                                            ie_next = 1'b0;
                                        default:
                                            ie_next = 1'b1;
                                    endcase
                                end
                                3'd4:
                                begin
                                    if (cond_f(op_x_y, f_reg))
                                    begin
                                        push_en  = 1'b1;
                                        push_val = pc_reg;
                                        pc_next  = imm16;
                                        states_next = 5'd17;
                                    end
                                    else
                                    begin
                                        states_next = 5'd11;
                                    end
                                end
                                3'd5:
                                begin
                                    push_en = 1'b1;
                                    if (!op_q)
                                    begin
                                        if (op_p == 2'd3)
                                        begin
                                            push_val = {a_reg, (f_reg & F_ALL) | F_PSW_ONE};
                                        end
                                        else
                                        begin
                                            push_val = rp_cur;
                                        end
                                        states_next = 5'd11;
                                    end
                                    else
                                    begin
                                        push_val    = pc_reg;
                                        pc_next     = imm16;
                                        states_next = 5'd17;
                                    end
                                end
                                3'd6:
                                begin
                                    t16    = alu_f(op_x_y, a_reg, imm_lo_reg, f_reg);
                                    f_next = t16[15:8];
                                    if (op_x_y != 3'd7) a_next = t16[7:0];
                                    states_next = 5'd7;
                                end
                                default:
                                begin
                                    push_en  = 1'b1;
                                    push_val = pc_reg;
                                    pc_next  = {10'd0, op_x_y, 3'd0};
                                    states_next = 5'd11;
                                end
                            endcase
                        end
                    endcase
                end

                // register write-back by r and rp codes
                if (r_we)
                begin
                    case (op_x_y)
                        3'd0:    b_next = r_val;
                        3'd1:    c_next = r_val;
                        3'd2:    d_next = r_val;
                        3'd3:    e_next = r_val;
                        3'd4:    h_next = r_val;
                        3'd5:    l_next = r_val;
                        3'd6:
                        begin
                            w1_en   = 1'b1;
                            w1_addr = hlw;
                            w1_data = r_val;
                        end
                        default: a_next = r_val;
                    endcase
                end
                if (rp_we)
                begin
                    w = rp_val;
                    case (op_p)
                        2'd0:
                        begin
                            b_next = w[15:8];
                            c_next = w[7:0];
                        end
                        2'd1:
                        begin
                            d_next = w[15:8];
                            e_next = w[7:0];
                        end
                        2'd2:
                        begin
                            h_next = w[15:8];
                            l_next = w[7:0];
                        end
                        default: sp_next = w;
                    endcase
                end
                if (push_en)
                begin
                    w1_en    = 1'b1;
                    w1_addr  = sp_reg - 16'd1;
                    w1_data  = push_val[15:8];
                    w2_en    = 1'b1;
                    wa2_next = sp_reg - 16'd2;
                    wd2_next = push_val[7:0];
                    sp_next  = sp_reg - 16'd2;
                end
                mem_we     = w1_en;
                mem_waddr  = w1_addr;
                mem_wdata  = w1_data;
                state_next = w2_en ? ST_WR2 : ST_DONE;
            end

            ST_WR2:
            begin
                mem_we     = 1'b1;
                state_next = ST_DONE;
            end

            ST_DONE:
                state_next = ST_IDLE;

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= 16'h0000;
            sp_reg        <= 16'h0000;
            b_reg <= 8'h00; c_reg <= 8'h00; d_reg <= 8'h00; e_reg <= 8'h00;
            h_reg <= 8'h00; l_reg <= 8'h00; a_reg <= 8'h00; f_reg <= 8'h00;
            ie_reg        <= 1'b0;
            halt_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_port_reg  <= 8'h00;
            out_data_reg  <= 8'h00;
            states_reg    <= 5'd0;
            kind_reg      <= KIND_LOAD;
            imm_cnt_reg   <= 2'd0;
            mrd_cnt_reg   <= 2'd0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            sp_reg        <= sp_next;
            b_reg <= b_next; c_reg <= c_next; d_reg <= d_next; e_reg <= e_next;
            h_reg <= h_next; l_reg <= l_next; a_reg <= a_next; f_reg <= f_next;
            ie_reg        <= ie_next;
            halt_reg      <= halt_next;
            out_valid_reg <= out_valid_next;
            out_port_reg  <= out_port_next;
            out_data_reg  <= out_data_next;
            states_reg    <= states_next;
            kind_reg      <= kind_next;
            imm_cnt_reg   <= imm_cnt_next;
            mrd_cnt_reg   <= mrd_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        imm_lo_reg <= imm_lo_next;
        imm_hi_reg <= imm_hi_next;
        md_lo_reg  <= md_lo_next;
        maddr_reg  <= maddr_next;
        wa2_reg    <= wa2_next;
        wd2_reg    <= wd2_next;
    end

    // ---------------- result word
    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

    always_comb
    begin
        result.prog_counter = pc_reg;
        result.stack_ptr    = sp_reg;
        result.accum        = a_reg;
        result.flag_byte    = f_reg & F_ALL;
        result.out_valid    = out_valid_reg;
        result.out_port     = out_port_reg;
        result.out_data     = out_data_reg;
        result.states_taken = states_reg;
        result.halted       = halt_reg;
    end

`ifndef SYNTHESIS
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_out_only_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.out_valid) |-> (kind_reg == KIND_EXEC))
        else $error("port write reported for a non-execute word");

    a_states_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.states_taken <= 5'd18))
        else $error("state count out of range");

    a_wr2_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WR2) |=> (state_reg == ST_DONE))
        else $error("second write did not finish the word");
`endif

endmodule
